// ===== hdl/gpfa_pkg.sv =====
// ---------------------------------------------------------------------------
// gpfa_pkg
// Shared types and constants for the gravity pair force accumulator.
// ---------------------------------------------------------------------------
package gpfa_pkg;

    localparam int COORD_BITS_DEFAULT = 32;
    localparam int FRAC_BITS_DEFAULT  = 40;

    localparam logic [63:0] FORCE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FORCE_MIN = 64'h8000_0000_0000_0000;

    // one pair item
    typedef struct packed {
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [31:0] target_z;
        logic [31:0] target_mass;
        logic [31:0] source_x;
        logic [31:0] source_y;
        logic [31:0] source_z;
        logic [31:0] source_mass;
        logic        first_of_target;
        logic        last_of_target;
    } pair_item_t;

    // one force result item
    typedef struct packed {
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
    } force_item_t;

endpackage

// ===== hdl/gravity_pair_force_accumulator_unit.sv =====
// ---------------------------------------------------------------------------
// gravity_pair_force_accumulator_unit
// Sums gravitational pair forces on one target into a saturating 3D total.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel pair_valid/pair_ready/pair_data carries one target/source
//   pair per item. first_of_target clears the total before the pair is
//   added, last_of_target sends the total on result_valid/result_ready/
//   result_data after the pair is added. Coincident points add nothing.
//   The block takes one item at a time; pair_ready is high only when idle.
//   The serial divider takes a bit count q = FORCE_FRACTION_BITS +
//   2*COORD_BITS + 3n (or that minus 3 - 3n when r^2 >= 2^64), where n
//   (0..31) is the number of 2-bit normalizing shifts of r^2; the divider
//   stops early on saturation. result_valid rises the cycle after the
//   item's last cycle.
//   One multiplier is shared by the squares, the divisor, the mass product
//   and the numerators; square root and division are bit serial.
//   Reset clears the force total and drops any pending result.
//   A result waits in an output register; if the receiver stalls, the next
//   item is still accepted and the block holds at its end until the
//   register is free.
// ---------------------------------------------------------------------------
module gravity_pair_force_accumulator_unit
    import gpfa_pkg::*;
#(
    parameter int COORD_BITS          = COORD_BITS_DEFAULT,
    parameter int FORCE_FRACTION_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_ready,
    input  pair_item_t  pair_data,
    output logic        result_valid,
    input  logic        result_ready,
    output force_item_t result_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_NORM = 4'd3;
    localparam logic [3:0] ST_ROOT = 4'd4;
    localparam logic [3:0] ST_DEN  = 4'd5;
    localparam logic [3:0] ST_PROD = 4'd6;
    localparam logic [3:0] ST_AXIS = 4'd7;
    localparam logic [3:0] ST_NLO  = 4'd8;
    localparam logic [3:0] ST_NHI  = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;

    localparam logic [7:0] CNT_BASE = 8'(FORCE_FRACTION_BITS + 2 * COORD_BITS);
    localparam logic [7:0] CNT_BIG  = 8'(FORCE_FRACTION_BITS + 2 * COORD_BITS - 3);

    logic [3:0]  state_reg, state_next;
    logic [1:0]  sub_reg, sub_next;
    logic [1:0]  axis_reg, axis_next;
    logic [31:0] ad_reg   [3];
    logic [31:0] ad_next  [3];
    logic [2:0]  neg_reg, neg_next;
    logic [31:0] mt_reg, mt_next;
    logic [31:0] ms_reg, ms_next;
    logic        last_reg, last_next;
    logic [65:0] ssum_reg, ssum_next;
    logic [63:0] s_reg, s_next;
    logic [4:0]  n_reg, n_next;
    logic        big_reg, big_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] plo_reg, plo_next;
    logic [63:0] acc_reg  [3];
    logic [63:0] acc_next [3];
    logic        rv_reg, rv_next;
    force_item_t res_reg, res_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        sq_start, sq_busy;
    logic [31:0] sq_root;
    logic        dv_start, dv_busy;
    logic [95:0] dv_num;
    logic [7:0]  dv_count;
    logic [63:0] dv_quot;

    // signed axis differences of the masked coordinates
    logic [COORD_BITS:0]   diff [3];
    logic [COORD_BITS-1:0] tgt  [3];
    logic [COORD_BITS-1:0] src  [3];

    // saturating accumulate of the current axis
    logic [63:0] acc_cur, addend, sum;
    logic        ovf;

    assign tgt[0] = pair_data.target_x[COORD_BITS-1:0];
    assign tgt[1] = pair_data.target_y[COORD_BITS-1:0];
    assign tgt[2] = pair_data.target_z[COORD_BITS-1:0];
    assign src[0] = pair_data.source_x[COORD_BITS-1:0];
    assign src[1] = pair_data.source_y[COORD_BITS-1:0];
    assign src[2] = pair_data.source_z[COORD_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {1'b0, src[i]} - {1'b0, tgt[i]};
        end
    end

    assign acc_cur = acc_reg[axis_reg];
    assign addend  = neg_reg[axis_reg] ? (64'd0 - dv_quot) : dv_quot;
    assign sum     = acc_cur + addend;
    assign ovf     = (acc_cur[63] == addend[63]) && (sum[63] != acc_cur[63]);

    // numerator and bit count for the divider
    assign dv_num   = {32'd0, plo_reg} + {mul_p, 32'd0};
    assign dv_count = big_reg ? CNT_BIG
                              : CNT_BASE + {2'b00, n_reg, 1'b0} + {3'b000, n_reg};

    gpfa_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    gpfa_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (s_reg),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    gpfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (den_reg),
        .count (dv_count),
        .busy  (dv_busy),
        .quot  (dv_quot)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        axis_next  = axis_reg;
        ad_next    = ad_reg;
        neg_next   = neg_reg;
        mt_next    = mt_reg;
        ms_next    = ms_reg;
        last_next  = last_reg;
        ssum_next  = ssum_reg;
        s_next     = s_reg;
        n_next     = n_reg;
        big_next   = big_reg;
        den_next   = den_reg;
        prod_next  = prod_reg;
        plo_next   = plo_reg;
        acc_next   = acc_reg;
        rv_next    = rv_reg;
        res_next   = res_reg;
        mul_a      = ad_reg[sub_reg];
        mul_b      = ad_reg[sub_reg];
        sq_start   = 1'b0;
        dv_start   = 1'b0;

        if (rv_reg && result_ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pair_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = diff[i][COORD_BITS];
                        ad_next[i]  = 32'(diff[i][COORD_BITS] ? -diff[i] : diff[i]);
                    end
                    mt_next   = pair_data.target_mass;
                    ms_next   = pair_data.source_mass;
                    last_next = pair_data.last_of_target;
                    if (pair_data.first_of_target)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_next[i] = '0;
                        end
                    end
                    ssum_next  = '0;
                    sub_next   = 2'd0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                // square issued at sub, summed in the next cycle
                if (sub_reg != 2'd0)
                begin
                    ssum_next = ssum_reg + {2'b00, mul_p};
                end
                if (sub_reg == 2'd3)
                begin
                    state_next = ST_CHK;
                end
                sub_next = sub_reg + 2'd1;
            end
            ST_CHK:
            begin
                n_next = '0;
                if (ssum_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else if (ssum_reg[65:64] != 2'b00)
                begin
                    s_next     = ssum_reg[65:2];
                    big_next   = 1'b1;
                    state_next = ST_NORM;
                end
                else
                begin
                    s_next     = ssum_reg[63:0];
                    big_next   = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (s_reg[63:62] == 2'b00)
                begin
                    s_next = {s_reg[61:0], 2'b00};
                    n_next = n_reg + 5'd1;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                mul_a = s_reg[63:32];
                mul_b = sq_root;
                if (!sq_busy)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                den_next   = mul_p;
                mul_a      = mt_reg;
                mul_b      = ms_reg;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                prod_next  = mul_p;
                axis_next  = 2'd0;
                state_next = ST_AXIS;
            end
            ST_AXIS:
            begin
                mul_a = ad_reg[axis_reg];
                mul_b = prod_reg[31:0];
                if (ad_reg[axis_reg] != '0)
                begin
                    state_next = ST_NLO;
                end
                else if (axis_reg == 2'd2)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_NLO:
            begin
                plo_next   = mul_p;
                mul_a      = ad_reg[axis_reg];
                mul_b      = prod_reg[63:32];
                state_next = ST_NHI;
            end
            ST_NHI:
            begin
                dv_start   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!dv_busy)
                begin
                    if (ovf)
                    begin
                        acc_next[axis_reg] = acc_cur[63] ? FORCE_MIN : FORCE_MAX;
                    end
                    else
                    begin
                        acc_next[axis_reg] = sum;
                    end
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_AXIS;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rv_reg || result_ready)
                begin
                    rv_next          = 1'b1;
                    res_next.force_x = acc_reg[0];
                    res_next.force_y = acc_reg[1];
                    res_next.force_z = acc_reg[2];
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sub_reg   <= '0;
            axis_reg  <= '0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            axis_reg  <= axis_next;
            rv_reg    <= rv_next;
            acc_reg   <= acc_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ad_reg   <= ad_next;
        neg_reg  <= neg_next;
        mt_reg   <= mt_next;
        ms_reg   <= ms_next;
        last_reg <= last_next;
        ssum_reg <= ssum_next;
        s_reg    <= s_next;
        n_reg    <= n_next;
        big_reg  <= big_next;
        den_reg  <= den_next;
        prod_reg <= prod_next;
        plo_reg  <= plo_next;
        res_reg  <= res_next;
    end

    assign pair_ready   = (state_reg == ST_IDLE);
    assign result_valid = rv_reg;
    assign result_data  = res_reg;

endmodule

// ===== hdl/gpfa_mul.sv =====
// ---------------------------------------------------------------------------
// gpfa_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
module gpfa_mul
    import gpfa_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // product is valid the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/gpfa_isqrt.sv =====
// ---------------------------------------------------------------------------
// gpfa_isqrt
// Iterative floor square root of a normalized 64-bit value, one result bit
// per cycle.
// ---------------------------------------------------------------------------
module gpfa_isqrt
    import gpfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        take;

    // trial subtraction
    assign trial = res_reg + bit_reg;
    assign take  = (x_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            x_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            x_reg    <= value;
            res_reg  <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

// ===== hdl/gpfa_div.sv =====
// ---------------------------------------------------------------------------
// gpfa_div
// Restoring bit-serial divider: 96-bit numerator over a 64-bit divisor,
// one quotient bit per cycle, saturating to the signed 64-bit maximum.
// ---------------------------------------------------------------------------
module gpfa_div
    import gpfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [95:0] num,
    input  logic [63:0] den,
    input  logic [7:0]  count,
    output logic        busy,
    output logic [63:0] quot
);

    logic        busy_reg;
    logic [95:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [7:0]  cnt_reg;
    logic [63:0] rem_sh;
    logic        ge;

    // shift in the next numerator bit (zeros past the binary point)
    assign rem_sh = {rem_reg[62:0], num_reg[95]};
    assign ge     = rem_reg[63] | (rem_sh >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= count;
        end
        else if (busy_reg)
        begin
            if (q_reg[63] | q_reg[62])
            begin
                // quotient would overflow: clamp and stop
                q_reg    <= FORCE_MAX;
                busy_reg <= 1'b0;
            end
            else
            begin
                rem_reg <= ge ? (rem_sh - den_reg) : rem_sh;
                q_reg   <= {q_reg[62:0], ge};
                num_reg <= {num_reg[94:0], 1'b0};
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ===== hdl/gpfa_checker.sv =====
// ---------------------------------------------------------------------------
// gpfa_checker
// Port-level checks for the gravity pair force accumulator.
// ---------------------------------------------------------------------------
module gpfa_checker
    import gpfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    input  logic        pair_ready,
    input  logic        result_valid,
    input  logic        result_ready,
    input  force_item_t result_data
);

    // a stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result item changed while stalled");

    // an accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_ready |=> !pair_ready)
        else $error("block ready right after accepting an item");

    // a new result appears only at the end of an item's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(pair_ready))
        else $error("result raised while block idle");

endmodule

bind gravity_pair_force_accumulator_unit gpfa_checker u_gpfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// ===== sim/gravity_pair_force_accumulator_unit_test.sv =====
// ---------------------------------------------------------------------------
// gravity_pair_force_accumulator_unit_test
// Drives target/source pair items into the force accumulator with random
// idling on both sides and checks every emitted force total against an
// in-bench predictor of the pair force arithmetic and saturating sums.
// ---------------------------------------------------------------------------
module gravity_pair_force_accumulator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gpfa_pkg::*;

    localparam int CB = COORD_BITS_DEFAULT;
    localparam int FB = FRAC_BITS_DEFAULT;
    localparam int STALL_LIMIT = 20000;

    // force total predictor and queue of expected totals
    class force_scoreboard;
        logic signed [63:0] total [3];
        force_item_t        pending [$];
        int                 errors;

        function new();
            total[0] = '0;
            total[1] = '0;
            total[2] = '0;
            errors = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // floor(ad * prod * 2^k / den), clamped to the positive limit
        function logic [63:0] axis_mag(logic [63:0] ad, logic [63:0] prod,
                                       logic [63:0] den, int k);
            logic [127:0] num;
            logic [63:0]  rem;
            logic [63:0]  q;
            logic         b;
            logic         top;
            int           p;
            num = ad * prod;
            rem = 0;
            q = 0;
            for (p = 95; p >= -k; p--)
            begin
                b = (p >= 0) ? num[p] : 1'b0;
                top = rem[63];
                rem = {rem[62:0], b};
                if (q >= (64'd1 << 62))
                    return FORCE_MAX;
                q = q << 1;
                if (top || rem >= den)
                begin
                    rem = rem - den;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function logic signed [63:0] clamp_add(logic signed [63:0] a,
                                               logic signed [63:0] b);
            logic signed [64:0] s;
            s = a + b;
            if (s > $signed({1'b0, FORCE_MAX}))
                return FORCE_MAX;
            if (s < $signed({1'b1, FORCE_MIN}))
                return FORCE_MIN;
            return s[63:0];
        endfunction

        function void note_pair(pair_item_t it);
            logic signed [33:0] d [3];
            logic [63:0]        ad [3];
            logic [65:0]        sq;
            logic [63:0]        s;
            logic [63:0]        den;
            logic [63:0]        prod;
            logic [63:0]        mag;
            force_item_t        res;
            int                 e;
            int                 k;
            int                 i;
            if (it.first_of_target)
            begin
                total[0] = '0;
                total[1] = '0;
                total[2] = '0;
            end
            d[0] = $signed({2'b0, it.source_x}) - $signed({2'b0, it.target_x});
            d[1] = $signed({2'b0, it.source_y}) - $signed({2'b0, it.target_y});
            d[2] = $signed({2'b0, it.source_z}) - $signed({2'b0, it.target_z});
            sq = 0;
            for (i = 0; i < 3; i++)
            begin
                ad[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
                sq = sq + 66'(ad[i] * ad[i]);
            end
            if (sq != 0)
            begin
                if (sq[65:64] != 0)
                begin
                    s = sq[65:2];
                    e = 2;
                end
                else
                begin
                    s = sq[63:0];
                    e = 0;
                    while (s < (64'd1 << 62))
                    begin
                        s = s << 2;
                        e = e - 2;
                    end
                end
                den = (s >> 32) * int_sqrt(s);
                k = FB + 2 * CB - 96 - (3 * e) / 2;
                prod = {32'b0, it.target_mass} * {32'b0, it.source_mass};
                for (i = 0; i < 3; i++)
                begin
                    if (ad[i] != 0)
                    begin
                        mag = axis_mag(ad[i], prod, den, k);
                        total[i] = clamp_add(total[i],
                            d[i] < 0 ? -$signed(mag) : $signed(mag));
                    end
                end
            end
            if (it.last_of_target)
            begin
                res.force_x = total[0];
                res.force_y = total[1];
                res.force_z = total[2];
                pending.push_back(res);
            end
        endfunction

        function void check_force(force_item_t got);
            force_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected force item %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.force_x !== want.force_x)
            begin
                $display("%0t: force_x expected %h actual %h", $time,
                         want.force_x, got.force_x);
                errors++;
            end
            if (got.force_y !== want.force_y)
            begin
                $display("%0t: force_y expected %h actual %h", $time,
                         want.force_y, got.force_y);
                errors++;
            end
            if (got.force_z !== want.force_z)
            begin
                $display("%0t: force_z expected %h actual %h", $time,
                         want.force_z, got.force_z);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        pair_valid;
    logic        pair_ready;
    pair_item_t  pair_data;
    logic        result_valid;
    logic        result_ready;
    force_item_t result_data;

    force_scoreboard sb;
    bit              calm;
    int              idle_cycles;

    gravity_pair_force_accumulator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair_data    (pair_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // sender gap: random burst before some items, valid dropped meanwhile
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 13);
            pair_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // valid stays high into the next item when there is no gap
    task automatic send_pair(pair_item_t it);
        sender_gap();
        pair_valid <= 1'b1;
        pair_data  <= it;
        @(posedge clk);
        while (!pair_ready)
            @(posedge clk);
        sb.note_pair(it);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000 + $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic pair_item_t make_pair(logic first, logic last);
        pair_item_t it;
        it.target_x = pick_coord();
        it.target_y = pick_coord();
        it.target_z = pick_coord();
        it.source_x = pick_coord();
        it.source_y = pick_coord();
        it.source_z = pick_coord();
        // nearby points exercise the small-distance shifts
        if ($urandom_range(0, 4) == 0)
        begin
            it.source_x = it.target_x + $urandom_range(0, 3);
            it.source_y = it.target_y - $urandom_range(0, 3);
            it.source_z = it.target_z + $urandom_range(0, 1);
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            it.source_x = it.target_x;
            it.source_y = it.target_y;
            it.source_z = it.target_z;
        end
        it.target_mass = pick_mass();
        it.source_mass = pick_mass();
        it.first_of_target = first;
        it.last_of_target  = last;
        return it;
    endfunction

    function automatic pair_item_t fixed_pair(logic [31:0] tx, logic [31:0] sx,
                                              logic [31:0] m, logic f, logic l);
        pair_item_t it;
        it = '0;
        it.target_x = tx;
        it.target_y = 32'h1234_5678;
        it.target_z = 32'h4000_0000;
        it.source_x = sx;
        it.source_y = 32'h1234_5678;
        it.source_z = 32'h4000_0000;
        it.target_mass = m;
        it.source_mass = m;
        it.first_of_target = f;
        it.last_of_target  = l;
        return it;
    endfunction

    // receiver: random stall bursts, checks each accepted result
    initial
    begin
        int n;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_force(result_data);
        end
    end

    // watchdog on cycles with no accepted item
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((pair_valid && pair_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("gravity_pair_force_accumulator_unit verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        pair_item_t it;
        int         len;
        int         j;
        int         sent;
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, coincident points, zero mass, saturation
        send_pair(fixed_pair(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_pair(fixed_pair(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_pair(fixed_pair(32'h5555_5555, 32'h5555_5555, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_pair(fixed_pair(32'h0, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_pair(fixed_pair(32'h0, 32'h1, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_pair(fixed_pair(32'h1, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_pair(fixed_pair(32'h10, 32'h11, 32'h0, 1'b1, 1'b1));
        send_pair(fixed_pair(32'h10, 32'h20, 32'h1, 1'b0, 1'b1));
        it = '0;
        it.source_x = 32'hFFFF_FFFF;
        it.source_y = 32'hFFFF_FFFF;
        it.source_z = 32'hFFFF_FFFF;
        it.target_mass = 32'hFFFF_FFFF;
        it.source_mass = 32'hFFFF_FFFF;
        it.first_of_target = 1'b1;
        it.last_of_target = 1'b1;
        send_pair(it);
        it.first_of_target = 1'b0;
        send_pair(it);
        it = ~it;
        it.first_of_target = 1'b1;
        it.last_of_target = 1'b1;
        send_pair(it);
        send_pair(make_pair(1'b0, 1'b0));
        send_pair(make_pair(1'b1, 1'b1));

        // random: mostly well-formed target groups, some loose pairs
        sent = 0;
        while (sent < 750)
        begin
            if (sent > 650)
                calm = 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                send_pair(make_pair(1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1))));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (j = 0; j < len; j++)
                    send_pair(make_pair(j == 0, j == len - 1));
                sent += len;
            end
        end
        pair_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
        if (sb.errors == 0)
            $display("gravity_pair_force_accumulator_unit verification clean");
        else
            $display("gravity_pair_force_accumulator_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gpfa_pkg.sv
hdl/gpfa_mul.sv
hdl/gpfa_isqrt.sv
hdl/gpfa_div.sv
hdl/gravity_pair_force_accumulator_unit.sv
hdl/gpfa_checker.sv
sim/gravity_pair_force_accumulator_unit_test.sv
